// ----- rtl/core/rthp_pkg.sv -----
`default_nettype none

package rthp_pkg;

    // channel and fraction widths
    localparam int CHANNEL_BITS  = 8;
    localparam int FRACTION_BITS = 16;

    // divider operands hold up to six times the chroma
    localparam int DIV_BITS   = CHANNEL_BITS + 3;
    // one integer quotient bit plus the fraction bits
    localparam int QUO_BITS   = FRACTION_BITS + 1;
    localparam int DIV_STAGES = QUO_BITS;

    // hue sector, chosen by the first channel that equals the maximum
    localparam logic [1:0] SEC_RED   = 2'd0;
    localparam logic [1:0] SEC_GREEN = 2'd1;
    localparam logic [1:0] SEC_BLUE  = 2'd2;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
    } t_in;

    typedef struct packed {
        logic [FRACTION_BITS-1:0] hue;
        logic [FRACTION_BITS-1:0] saturation;
        logic [CHANNEL_BITS-1:0]  brightness;
    } t_out;

    // word carried through the divider stages
    typedef struct packed {
        logic [DIV_BITS-1:0]     rem_s;
        logic [DIV_BITS-1:0]     den_s;
        logic [QUO_BITS-1:0]     quo_s;
        logic [DIV_BITS-1:0]     rem_h;
        logic [DIV_BITS-1:0]     den_h;
        logic [QUO_BITS-1:0]     quo_h;
        logic                    neg;
        logic                    gray;
        logic                    black;
        logic [CHANNEL_BITS-1:0] value;
    } t_div_word;

    // one restoring division step for both quotients
    function automatic t_div_word rthp_step(input t_div_word w, input logic shift_en);
        t_div_word          o;
        logic [DIV_BITS:0]  rs;
        logic [DIV_BITS:0]  rh;
        logic               bs;
        logic               bh;
        o  = w;
        rs = shift_en ? {w.rem_s, 1'b0} : {1'b0, w.rem_s};
        rh = shift_en ? {w.rem_h, 1'b0} : {1'b0, w.rem_h};
        bs = (rs >= {1'b0, w.den_s});
        bh = (rh >= {1'b0, w.den_h});
        if (bs) begin
            rs = rs - {1'b0, w.den_s};
        end
        if (bh) begin
            rh = rh - {1'b0, w.den_h};
        end
        o.rem_s = rs[DIV_BITS-1:0];
        o.rem_h = rh[DIV_BITS-1:0];
        o.quo_s = {w.quo_s[QUO_BITS-2:0], bs};
        o.quo_h = {w.quo_h[QUO_BITS-2:0], bh};
        return o;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rthp_front.sv -----
`default_nettype none

module rthp_front
    import rthp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_in       i_data,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_div_word      o_data
);

    // stage a: extremes and sector
    logic                    r_va;
    logic [CHANNEL_BITS-1:0] r_red;
    logic [CHANNEL_BITS-1:0] r_green;
    logic [CHANNEL_BITS-1:0] r_blue;
    logic [CHANNEL_BITS-1:0] r_max;
    logic [CHANNEL_BITS-1:0] r_min;
    logic [1:0]              r_sec;

    logic [CHANNEL_BITS-1:0] n_max;
    logic [CHANNEL_BITS-1:0] n_min;
    logic [1:0]              n_sec;

    // stage b: divider operands
    logic                    r_vb;
    t_div_word               r_word;
    t_div_word               n_word;

    logic                    rdy_a;
    logic                    rdy_b;

    assign rdy_b   = !r_vb || i_ready;
    assign rdy_a   = !r_va || rdy_b;
    assign o_ready = rdy_a;
    assign o_valid = r_vb;
    assign o_data  = r_word;

    // max, min and the winning channel with red first
    always_comb begin
        logic [CHANNEL_BITS-1:0] m_rg;
        logic [CHANNEL_BITS-1:0] l_rg;
        m_rg  = (i_data.red > i_data.green) ? i_data.red : i_data.green;
        l_rg  = (i_data.red < i_data.green) ? i_data.red : i_data.green;
        n_max = (m_rg > i_data.blue) ? m_rg : i_data.blue;
        n_min = (l_rg < i_data.blue) ? l_rg : i_data.blue;
        priority if (n_max == i_data.red) begin
            n_sec = SEC_RED;
        end else if (n_max == i_data.green) begin
            n_sec = SEC_GREEN;
        end else begin
            n_sec = SEC_BLUE;
        end
    end

    // chroma, sector numerator as sign and magnitude, six times chroma
    always_comb begin
        logic [DIV_BITS-1:0] c;
        logic [DIV_BITS-1:0] pos;
        logic [DIV_BITS-1:0] ng;
        c = DIV_BITS'(r_max - r_min);
        unique case (r_sec)
            SEC_GREEN: begin
                pos = (c << 1) + DIV_BITS'(r_blue);
                ng  = DIV_BITS'(r_red);
            end
            SEC_BLUE: begin
                pos = (c << 2) + DIV_BITS'(r_red);
                ng  = DIV_BITS'(r_green);
            end
            default: begin
                pos = DIV_BITS'(r_green);
                ng  = DIV_BITS'(r_blue);
            end
        endcase
        n_word.rem_s = c;
        n_word.den_s = DIV_BITS'(r_max);
        n_word.quo_s = '0;
        n_word.neg   = (pos < ng);
        n_word.rem_h = (pos < ng) ? (ng - pos) : (pos - ng);
        n_word.den_h = (c << 2) + (c << 1);
        n_word.quo_h = '0;
        n_word.gray  = (c == '0);
        n_word.black = (r_max == '0);
        n_word.value = r_max;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_va <= i_valid;
            end
            if (rdy_b) begin
                r_vb <= r_va;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a) begin
            r_red   <= i_data.red;
            r_green <= i_data.green;
            r_blue  <= i_data.blue;
            r_max   <= n_max;
            r_min   <= n_min;
            r_sec   <= n_sec;
        end
        if (rdy_b) begin
            r_word <= n_word;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/rthp_div_pipe.sv -----
`default_nettype none

module rthp_div_pipe
    import rthp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_div_word i_data,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_div_word      o_data
);

    logic      r_v    [DIV_STAGES];
    t_div_word r_word [DIV_STAGES];
    logic      rdy    [DIV_STAGES+1];

    assign rdy[DIV_STAGES] = i_ready;
    assign o_ready         = rdy[0];
    assign o_valid         = r_v[DIV_STAGES-1];
    assign o_data          = r_word[DIV_STAGES-1];

    // one quotient bit per stage, integer bit first
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic      src_v;
        t_div_word src_w;

        if (k == 0) begin : g_first
            assign src_v = i_valid;
            assign src_w = rthp_step(i_data, 1'b0);
        end else begin : g_next
            assign src_v = r_v[k-1];
            assign src_w = rthp_step(r_word[k-1], 1'b1);
        end

        assign rdy[k] = !r_v[k] || rdy[k+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (rdy[k]) begin
                r_v[k] <= src_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (rdy[k]) begin
                r_word[k] <= src_w;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/rthp_back.sv -----
`default_nettype none

module rthp_back
    import rthp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_div_word i_data,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out           o_data
);

    logic r_v;
    t_out r_out;
    t_out n_out;

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign o_data  = r_out;

    // wrap negative hue with a rounded-up magnitude, clamp, special cases
    always_comb begin
        logic [QUO_BITS-1:0] up;
        logic [QUO_BITS-1:0] wrapped;
        up      = i_data.quo_h + QUO_BITS'(i_data.rem_h != '0);
        wrapped = {1'b1, {FRACTION_BITS{1'b0}}} - up;
        if (i_data.gray) begin
            n_out.hue = '0;
        end else if (i_data.neg) begin
            n_out.hue = wrapped[FRACTION_BITS-1:0];
        end else if (i_data.quo_h[FRACTION_BITS]) begin
            n_out.hue = '1;
        end else begin
            n_out.hue = i_data.quo_h[FRACTION_BITS-1:0];
        end

        if (i_data.black) begin
            n_out.saturation = '0;
        end else if (i_data.quo_s[FRACTION_BITS]) begin
            n_out.saturation = '1;
        end else begin
            n_out.saturation = i_data.quo_s[FRACTION_BITS-1:0];
        end

        n_out.brightness = i_data.value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/rgb_to_hsv_pixel.sv -----
`default_nettype none

// RGB to HSV pixel converter. Takes one pixel per clock, when not stalled,
// on a valid/ready stream and returns hue and saturation as 16-bit fractions
// (hue: 65536 is one turn; saturation: 1.0 reads 65535) and brightness as
// max(r,g,b), all truncated. Gray pixels give hue 0, black pixels give
// saturation 0. The path has two front stages, a restoring divider that
// settles one quotient bit per stage for both ratios in parallel, and an
// output register. Throughput is one pixel per clock while the output is
// not stalled; each stage holds its word only while the stage after it is
// full and stalled, so bubbles close up under back-pressure.

module rgb_to_hsv_pixel
    import rthp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    logic      front_valid;
    logic      front_ready;
    t_div_word front_word;
    logic      div_valid;
    logic      div_ready;
    t_div_word div_word;

    // extremes, chroma and divider operands
    rthp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .o_valid (front_valid),
        .i_ready (front_ready),
        .o_data  (front_word)
    );

    // saturation and hue quotients
    rthp_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_data  (front_word),
        .o_valid (div_valid),
        .i_ready (div_ready),
        .o_data  (div_word)
    );

    // wrap, clamp and output register
    rthp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div_valid),
        .o_ready (div_ready),
        .i_data  (div_word),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ----- sim/rgb_to_hsv_pixel_tb.sv -----
`default_nettype none

module rgb_to_hsv_pixel_tb;
    import rthp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 8;
    localparam int PIPE_LATENCY   = 3 + QUO_BITS;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RX_HOLD_CYCLES = 200;
    localparam int MAX_REPORTS    = 10;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    t_in  in_word   = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_word;

    // expected hsv words, oldest first
    t_out expected_hsv[$];
    int   err_count    = 0;
    int   stall_cycles = 0;
    bit   tx_steady    = 1'b0;
    bit   rx_steady    = 1'b0;
    bit   rx_hold_req  = 1'b0;

    rgb_to_hsv_pixel dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_word)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // gap length: mostly short, now and then long
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(15, 60);
    endfunction

    function automatic t_in pixel(input int r, input int g, input int b);
        t_in px;
        px.red   = r[CHANNEL_BITS-1:0];
        px.green = g[CHANNEL_BITS-1:0];
        px.blue  = b[CHANNEL_BITS-1:0];
        return px;
    endfunction

    // fixed point hsv of one pixel, floored to the output grid
    function automatic t_out convert_pixel(input t_in px);
        t_out        res;
        logic [1:0]  sector;
        logic [63:0] r, g, b, v, mn, c, sat, hue, pos, neg, den, mag, up;
        logic [63:0] fr_one;
        fr_one = 64'd1 << FRACTION_BITS;
        r  = 64'(px.red);
        g  = 64'(px.green);
        b  = 64'(px.blue);
        v  = (r > g) ? r : g;
        v  = (v > b) ? v : b;
        mn = (r < g) ? r : g;
        mn = (mn < b) ? mn : b;
        c  = v - mn;
        sat = '0;
        hue = '0;

        // saturation, zero for black, clamped at one
        if (v != 0) begin
            sat = (c << FRACTION_BITS) / v;
            if (sat > fr_one - 1) begin
                sat = fr_one - 1;
            end
        end

        // hue, zero for gray, sector picked red then green then blue
        if (c != 0) begin
            den = 6 * c;
            if (v == r) begin
                sector = SEC_RED;
            end else if (v == g) begin
                sector = SEC_GREEN;
            end else begin
                sector = SEC_BLUE;
            end
            case (sector)
                SEC_RED: begin
                    pos = g;
                    neg = b;
                end
                SEC_GREEN: begin
                    pos = 2 * c + b;
                    neg = r;
                end
                default: begin
                    pos = 4 * c + r;
                    neg = g;
                end
            endcase
            if (pos >= neg) begin
                hue = ((pos - neg) << FRACTION_BITS) / den;
            end else begin
                // negative offset wraps by one turn, floor of the wrapped value
                mag = (neg - pos) << FRACTION_BITS;
                up  = (mag + den - 1) / den;
                hue = fr_one - up;
            end
            if (hue > fr_one - 1) begin
                hue = fr_one - 1;
            end
        end

        res.hue        = hue[FRACTION_BITS-1:0];
        res.saturation = sat[FRACTION_BITS-1:0];
        res.brightness = v[CHANNEL_BITS-1:0];
        return res;
    endfunction

    // random pixel, biased toward gray, ties, extremes and tiny values
    function automatic t_in random_pixel();
        int kind, v, lo, w;
        kind = $urandom_range(0, 99);
        if (kind < 50) begin
            return pixel($urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255));
        end else if (kind < 60) begin
            v = $urandom_range(0, 255);
            return pixel(v, v, v);
        end else if (kind < 70) begin
            v  = $urandom_range(0, 255);
            lo = $urandom_range(0, v);
            w  = $urandom_range(0, 2);
            if (w == 0) return pixel(v, v, lo);
            if (w == 1) return pixel(v, lo, v);
            return pixel(lo, v, v);
        end else if (kind < 80) begin
            v = $urandom_range(0, 255);
            w = $urandom_range(0, 5);
            case (w)
                0: return pixel(255, 0, v);
                1: return pixel(255, v, 0);
                2: return pixel(0, 255, v);
                3: return pixel(v, 255, 0);
                4: return pixel(0, v, 255);
                default: return pixel(v, 0, 255);
            endcase
        end else if (kind < 90) begin
            return pixel($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3));
        end
        return pixel($urandom_range(252, 255), $urandom_range(252, 255),
                     $urandom_range(0, 255));
    endfunction

    // offer one pixel word and wait until it is taken
    task automatic send_pixel(input t_in px);
        int gap;
        gap = 0;
        if (!tx_steady && $urandom_range(0, 99) >= 60) begin
            gap = pick_gap();
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= px;
        do begin
            @(posedge clk);
        end while (!in_ready);
        expected_hsv.push_back(convert_pixel(px));
    endtask

    // extremes, every sector, ties, gray, black and wrap-around
    task automatic test_directed();
        send_pixel(pixel(0, 0, 0));
        send_pixel(pixel(255, 255, 255));
        send_pixel(pixel(128, 128, 128));
        send_pixel(pixel(1, 1, 1));
        send_pixel(pixel(255, 0, 0));
        send_pixel(pixel(0, 255, 0));
        send_pixel(pixel(0, 0, 255));
        send_pixel(pixel(255, 255, 0));
        send_pixel(pixel(0, 255, 255));
        send_pixel(pixel(255, 0, 255));
        send_pixel(pixel(255, 0, 1));
        send_pixel(pixel(255, 0, 128));
        send_pixel(pixel(200, 10, 199));
        send_pixel(pixel(10, 200, 50));
        send_pixel(pixel(50, 200, 10));
        send_pixel(pixel(50, 10, 200));
        send_pixel(pixel(10, 50, 200));
        send_pixel(pixel(1, 0, 0));
        send_pixel(pixel(0, 0, 1));
        send_pixel(pixel(1, 1, 0));
        send_pixel(pixel(254, 255, 253));
        send_pixel(pixel(255, 254, 255));
        send_pixel(pixel(170, 85, 0));
    endtask

    // random pixels with idling on both sides
    task automatic test_random(input int count);
        int i;
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        for (i = 0; i < count; i++) begin
            send_pixel(random_pixel());
        end
    endtask

    // back to back words, no idling anywhere
    task automatic test_streaming(input int count);
        int i;
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        for (i = 0; i < count; i++) begin
            send_pixel(random_pixel());
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // receiver holds off while the sender keeps offering, pipeline fills
    task automatic test_backpressure(input int count);
        int i;
        tx_steady   = 1'b1;
        rx_hold_req = 1'b1;
        for (i = 0; i < count; i++) begin
            send_pixel(random_pixel());
        end
        tx_steady = 1'b0;
    endtask

    // receiver ready, random stalls and the long hold-off
    initial begin
        int rx_stall;
        int k;
        rx_stall = 0;
        forever begin
            @(posedge clk);
            if (rx_hold_req) begin
                out_ready <= 1'b0;
                for (k = 0; k < RX_HOLD_CYCLES; k++) begin
                    @(posedge clk);
                end
                rx_hold_req = 1'b0;
            end else if (rx_stall > 0) begin
                out_ready <= 1'b0;
                rx_stall--;
            end else begin
                out_ready <= 1'b1;
                if (!rx_steady && $urandom_range(0, 99) < 20) begin
                    rx_stall = pick_gap();
                end
            end
        end
    end

    // compare each result word with the oldest expected one
    always @(posedge clk) begin
        t_out exp_word;
        if (out_valid && out_ready) begin
            if (expected_hsv.size() == 0) begin
                if (err_count < MAX_REPORTS) begin
                    $display("unexpected result word: hue %0d sat %0d val %0d",
                             out_word.hue, out_word.saturation, out_word.brightness);
                end
                err_count++;
            end else begin
                exp_word = expected_hsv.pop_front();
                if (out_word.hue != exp_word.hue ||
                    out_word.saturation != exp_word.saturation ||
                    out_word.brightness != exp_word.brightness) begin
                    if (err_count < MAX_REPORTS) begin
                        $write("mismatch: expected hue %0d sat %0d val %0d,",
                               exp_word.hue, exp_word.saturation, exp_word.brightness);
                        $display(" got hue %0d sat %0d val %0d",
                                 out_word.hue, out_word.saturation, out_word.brightness);
                    end
                    err_count++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("rgb_to_hsv_pixel_tb NOT OK");
                $finish;
            end
        end
    end

    // test sequence
    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(300);
        test_streaming(100);
        test_backpressure(60);
        test_random(50);

        in_valid <= 1'b0;
        while (expected_hsv.size() != 0) begin
            @(posedge clk);
        end
        repeat (PIPE_LATENCY + 4) @(posedge clk);

        if (err_count == 0) begin
            $display("rgb_to_hsv_pixel_tb OK");
        end else begin
            $display("rgb_to_hsv_pixel_tb NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
